// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of the button qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/httbq_pkg.sv =====
// Types and constants shared by the hold-to-trigger button qualifier.
package httbq_pkg;

	localparam int unsigned MAX_BUTTONS     = 4;
	localparam int unsigned NUM_BUTTONS_DEF = 4;
	localparam int unsigned COUNT_W         = 16;
	localparam int unsigned CFG_IDX_W       = 3;

	localparam logic [COUNT_W-1:0] HOLD_RESET = 16'd100;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [1:0] {
		PH_READY     = 2'd0,
		PH_WAITING   = 2'd1,
		PH_TRIGGERED = 2'd2
	} phase_t;

	typedef struct packed {
		logic set_flag;
		logic clr_flag;
	} btn_ctl_t;

endpackage

// ===== hdl/httbq_button.sv =====
// Next-state logic of one button: phase, deadline and pressed-flag control.
module httbq_button (
	input  httbq_pkg::phase_t                     phase,
	input  logic [httbq_pkg::COUNT_W-1:0]         deadline,
	input  logic [httbq_pkg::COUNT_W-1:0]         hold,
	input  logic [httbq_pkg::COUNT_W-1:0]         count,
	input  logic                                  held,
	output httbq_pkg::phase_t                     phase_nxt,
	output logic [httbq_pkg::COUNT_W-1:0]         deadline_nxt,
	output logic                                  deadline_we,
	output httbq_pkg::btn_ctl_t                   ctl
);
	import httbq_pkg::*;

	// The deadline wraps at 16 bits like the tick counter.
	assign deadline_nxt = count + hold;

	always_comb begin
		phase_nxt    = phase;
		deadline_we  = 1'b0;
		ctl.set_flag = 1'b0;
		ctl.clr_flag = 1'b0;
		unique case (phase)
			PH_READY: begin
				if (held) begin
					phase_nxt   = PH_WAITING;
					deadline_we = 1'b1;
				end
			end
			PH_WAITING: begin
				if (!held) begin
					phase_nxt = PH_READY;
				end else if (count == deadline) begin
					phase_nxt    = PH_TRIGGERED;
					ctl.set_flag = 1'b1;
				end
			end
			PH_TRIGGERED: begin
				if (!held) begin
					phase_nxt = PH_READY;
				end
			end
			default: begin
				// The spare phase code recovers to ready and drops the flag.
				phase_nxt    = PH_READY;
				ctl.clr_flag = 1'b1;
			end
		endcase
	end

endmodule

// ===== hdl/hold_to_trigger_button_qualifier_core.sv =====
// Top level of the hold-to-trigger button qualifier.
// A request is registered, then processed into the result register; a stalled
// output holds it in the request register. Throughput: one request per cycle
// unless the output stalls, set by the single-pass per-button update.
// Reset clears button phases, pressed flags, hold times (to 100) and the valid
// flags; deadline registers are written before use and have no reset.
module hold_to_trigger_button_qualifier_core #(
	parameter int unsigned NUM_BUTTONS = httbq_pkg::NUM_BUTTONS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic                                  cmd,
	input  logic [httbq_pkg::COUNT_W-1:0]         tick_count,
	input  logic [httbq_pkg::MAX_BUTTONS-1:0]     button_levels,
	input  logic [httbq_pkg::MAX_BUTTONS-1:0]     clear_mask,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output logic [httbq_pkg::MAX_BUTTONS-1:0]     pressed_mask,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [httbq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [httbq_pkg::COUNT_W-1:0]         cfg_data
);
	import httbq_pkg::*;

	logic                       req_valid_s1;
	logic                       cmd_s1;
	logic [COUNT_W-1:0]         count_s1;
	logic [MAX_BUTTONS-1:0]     levels_s1;
	logic [MAX_BUTTONS-1:0]     clear_s1;

	logic [COUNT_W-1:0]         hold_q     [NUM_BUTTONS];
	phase_t                     phase_q    [NUM_BUTTONS];
	logic [COUNT_W-1:0]         deadline_q [NUM_BUTTONS];
	logic [MAX_BUTTONS-1:0]     flags_q;
	logic                       rsp_valid_q;
	logic [MAX_BUTTONS-1:0]     mask_q;

	phase_t                     phase_nxt    [NUM_BUTTONS];
	logic [COUNT_W-1:0]         deadline_nxt [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]     deadline_we;
	btn_ctl_t                   ctl          [NUM_BUTTONS];

	logic                       advance;
	logic                       tick_go;
	logic [MAX_BUTTONS-1:0]     set_v;
	logic [MAX_BUTTONS-1:0]     clr_v;
	logic [MAX_BUTTONS-1:0]     flags_tick;
	logic [MAX_BUTTONS-1:0]     flags_nxt;
	logic [MAX_BUTTONS-1:0]     result;

	// The stage moves on whenever the result register is empty or being drained.
	assign advance   = req_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign tick_go   = advance && (cmd_s1 == CMD_TICK);
	assign req_stall = req_valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_s1    <= cmd;
			count_s1  <= tick_count;
			levels_s1 <= button_levels;
			clear_s1  <= clear_mask;
		end
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
		httbq_button u_btn (
			.phase        (phase_q[i]),
			.deadline     (deadline_q[i]),
			.hold         (hold_q[i]),
			.count        (count_s1),
			.held         (levels_s1[i]),
			.phase_nxt    (phase_nxt[i]),
			.deadline_nxt (deadline_nxt[i]),
			.deadline_we  (deadline_we[i]),
			.ctl          (ctl[i])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hold_q[i]  <= HOLD_RESET;
				phase_q[i] <= PH_READY;
			end else begin
				if (cfg_valid && cfg_ready && (cfg_index == CFG_IDX_W'(i))) begin
					hold_q[i] <= cfg_data;
				end
				if (tick_go) begin
					phase_q[i] <= phase_nxt[i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (tick_go && deadline_we[i]) begin
				deadline_q[i] <= deadline_nxt[i];
			end
		end
	end

	always_comb begin
		set_v = '0;
		clr_v = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			set_v[i] = ctl[i].set_flag;
			clr_v[i] = ctl[i].clr_flag;
		end
	end

	// A tick reports the flags after its update; a read reports, then clears.
	assign flags_tick = (flags_q | set_v) & ~clr_v;
	assign flags_nxt  = (cmd_s1 == CMD_TICK) ? flags_tick : (flags_q & ~clear_s1);
	assign result     = (cmd_s1 == CMD_TICK) ? flags_tick : flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				flags_q     <= flags_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_q <= result;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign pressed_mask = mask_q;

endmodule

// ===== hdl/httbq_checker.sv =====
// Port-level checker for the hold-to-trigger button qualifier, with its bind.
`include "assert_macros.svh"

module httbq_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  req_valid,
	input logic                                  req_stall,
	input logic                                  rsp_valid,
	input logic                                  rsp_stall,
	input logic [httbq_pkg::MAX_BUTTONS-1:0]     pressed_mask,
	input logic                                  cfg_valid,
	input logic                                  cfg_ready
);
	import httbq_pkg::*;

	// A stalled result stays up and unchanged.
	`ASSERT_CLK(a_rsp_hold, clk, arst_n, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(pressed_mask)), "stalled result changed")

	// Requests back up only when a result is waiting and the consumer stalls.
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, req_stall, rsp_valid && rsp_stall, "request stalled without a blocked result")

	// Configuration writes are never refused.
	`ASSERT_IMPLIES(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind hold_to_trigger_button_qualifier_core httbq_checker u_httbq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_stall    (req_stall),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.pressed_mask (pressed_mask),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

// ===== test/hold_to_trigger_button_qualifier_core_check.sv =====
// Checker for the button qualifier: predicts pressed_mask per request and compares responses.
`timescale 1ns / 1ps
module hold_to_trigger_button_qualifier_core_check
	import httbq_pkg::*;
#(
	parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_stall,
	input  logic                   cmd,
	input  logic [COUNT_W-1:0]     tick_count,
	input  logic [MAX_BUTTONS-1:0] button_levels,
	input  logic [MAX_BUTTONS-1:0] clear_mask,
	input  logic                   rsp_valid,
	input  logic                   rsp_stall,
	input  logic [MAX_BUTTONS-1:0] pressed_mask,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COUNT_W-1:0]     cfg_data,
	output int unsigned            mismatch_count,
	output int unsigned            awaited_count
);

	phase_t                 button_phase [MAX_BUTTONS];
	logic [COUNT_W-1:0]     hold_ticks [MAX_BUTTONS];
	logic [COUNT_W-1:0]     deadline [MAX_BUTTONS];
	logic [MAX_BUTTONS-1:0] latched_flags;
	logic [MAX_BUTTONS-1:0] awaited_masks [$];
	logic [MAX_BUTTONS-1:0] oldest_mask;
	logic                   held;

	// Every signal is driven at the rising edge, so the values seen at the falling edge
	// are the ones the next rising edge acts on.
	always @(negedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BUTTONS; i++) begin
				button_phase[i] = PH_READY;
				hold_ticks[i] = HOLD_RESET;
			end
			latched_flags = '0;
			awaited_masks.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < MAX_BUTTONS)
				hold_ticks[cfg_index] = cfg_data;

			if (rsp_valid && !rsp_stall) begin
				if (awaited_masks.size() == 0) begin
					$error("pressed_mask: no response expected, actual %h", pressed_mask);
					mismatch_count++;
				end else begin
					oldest_mask = awaited_masks.pop_front();
					if (pressed_mask !== oldest_mask) begin
						$error("pressed_mask: expected %h, actual %h", oldest_mask,
							pressed_mask);
						mismatch_count++;
					end
				end
			end

			if (req_valid && !req_stall) begin
				if (cmd == CMD_TICK) begin
					for (int i = 0; i < NUM_BUTTONS && i < MAX_BUTTONS; i++) begin
						held = button_levels[i];
						case (button_phase[i])
							PH_READY: begin
								if (held) begin
									button_phase[i] = PH_WAITING;
									deadline[i] = tick_count + hold_ticks[i];
								end
							end
							PH_WAITING: begin
								if (!held) begin
									button_phase[i] = PH_READY;
								end else if (tick_count == deadline[i]) begin
									button_phase[i] = PH_TRIGGERED;
									latched_flags[i] = 1'b1;
								end
							end
							PH_TRIGGERED: begin
								if (!held)
									button_phase[i] = PH_READY;
							end
							default: begin
								button_phase[i] = PH_READY;
								latched_flags[i] = 1'b0;
							end
						endcase
					end
					awaited_masks.push_back(latched_flags);
				end else begin
					// A read reports the flags first and clears them afterwards.
					awaited_masks.push_back(latched_flags);
					latched_flags = latched_flags & ~clear_mask;
				end
			end
		end
		awaited_count = awaited_masks.size();
	end

endmodule

// ===== test/hold_to_trigger_button_qualifier_core_test.sv =====
// Stimulus and verdict for the hold-to-trigger button qualifier testbench.
`timescale 1ns / 1ps
module hold_to_trigger_button_qualifier_core_test;
	import httbq_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD_BUTTON0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_BUTTON1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_BUTTON2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_BUTTON3 = 3'd3;
	localparam int unsigned REG_FIRST_UNUSED = 4;
	localparam int unsigned REG_LAST_UNUSED  = 7;

	localparam int NUM_PHASES     = 8;
	localparam int PHASE_REQUESTS = 228;
	localparam int HOLD_OFF_PHASE = 3;
	localparam int LONG_HOLD_OFF  = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 8;

	typedef enum logic [1:0] {
		STALL_NEVER,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_CHOKED
	} stall_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_stall;
	logic                   cmd = CMD_TICK;
	logic [COUNT_W-1:0]     tick_count = '0;
	logic [MAX_BUTTONS-1:0] button_levels = '0;
	logic [MAX_BUTTONS-1:0] clear_mask = '0;
	logic                   rsp_valid;
	logic                   rsp_stall = 1'b0;
	logic [MAX_BUTTONS-1:0] pressed_mask;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [COUNT_W-1:0]     cfg_data = '0;

	int unsigned mismatch_count;
	int unsigned awaited_count;

	int          burst_left = 0;
	bit          steady_sender = 1'b0;
	int          hold_off_asked = 0;
	int          hold_off_seen = 0;
	int          hold_off_left = 0;
	stall_mode_t stall_mode = STALL_NEVER;
	int          stall_mode_left = 0;
	int          idle_cycles = 0;

	logic [COUNT_W-1:0]     tick_now = '0;
	logic [MAX_BUTTONS-1:0] held_now = '0;

	always #1 clk = ~clk;

	hold_to_trigger_button_qualifier_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.tick_count(tick_count),
		.button_levels(button_levels),
		.clear_mask(clear_mask),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.pressed_mask(pressed_mask),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	hold_to_trigger_button_qualifier_core_check #(
		.NUM_BUTTONS(NUM_BUTTONS_DEF)
	) mask_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.tick_count(tick_count),
		.button_levels(button_levels),
		.clear_mask(clear_mask),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.pressed_mask(pressed_mask),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.awaited_count(awaited_count)
	);

	// Response side: a long hold-off on request, otherwise stall patterns that change now
	// and then, including stretches with no stall at all.
	always @(posedge clk) begin
		if (hold_off_seen != hold_off_asked) begin
			hold_off_seen <= hold_off_asked;
			hold_off_left <= LONG_HOLD_OFF;
			rsp_stall <= 1'b1;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			if (stall_mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				stall_mode_left <= $urandom_range(16, 160);
			end else begin
				stall_mode_left <= stall_mode_left - 1;
			end
			case (stall_mode)
				STALL_NEVER: rsp_stall <= 1'b0;
				STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: rsp_stall <= 1'($urandom_range(0, 1));
				default:     rsp_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(negedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Called right after a rising edge; returns right after the edge that took the request.
	task automatic send_request(input logic c, input logic [COUNT_W-1:0] cnt,
		input logic [MAX_BUTTONS-1:0] lv, input logic [MAX_BUTTONS-1:0] clr);
		int  gap;
		bit  taken;
		if (burst_left == 0 && !steady_sender) begin
			gap = $urandom_range(0, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else if (burst_left > 0) begin
			burst_left--;
		end
		req_valid <= 1'b1;
		cmd <= c;
		tick_count <= cnt;
		button_levels <= lv;
		clear_mask <= clr;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaited_count != 0)
			@(posedge clk);
	endtask

	// Writes all four hold times plus one write to an unused index, which must be ignored.
	task automatic load_hold_times(input logic [COUNT_W-1:0] t0, input logic [COUNT_W-1:0] t1,
		input logic [COUNT_W-1:0] t2, input logic [COUNT_W-1:0] t3);
		logic [CFG_IDX_W-1:0] idx [5];
		logic [COUNT_W-1:0]   val [5];
		bit                   taken;
		idx[0] = REG_HOLD_BUTTON0;
		idx[1] = REG_HOLD_BUTTON1;
		idx[2] = REG_HOLD_BUTTON2;
		idx[3] = REG_HOLD_BUTTON3;
		idx[4] = CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED));
		val[0] = t0;
		val[1] = t1;
		val[2] = t2;
		val[3] = t3;
		val[4] = COUNT_W'($urandom);
		for (int k = 0; k < 5; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			taken = 1'b0;
			while (!taken) begin
				@(negedge clk);
				taken = cfg_ready;
				@(posedge clk);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [COUNT_W-1:0] pick_hold();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return COUNT_W'($urandom_range(1, 24));
	endfunction

	// Mostly a counter that steps forward with buttons held for a while, so that deadlines
	// are actually reached; a share of fully random requests is mixed in.
	task automatic run_phase(input int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				send_request(1'($urandom), COUNT_W'($urandom), MAX_BUTTONS'($urandom),
					MAX_BUTTONS'($urandom));
			end else if (r < 28) begin
				send_request(CMD_READ, COUNT_W'($urandom), held_now, MAX_BUTTONS'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				if (r >= 8) begin
					if (r < 80)
						tick_now = tick_now + 1'b1;
					else if (r < 96)
						tick_now = tick_now + COUNT_W'($urandom_range(2, 6));
					else
						tick_now = COUNT_W'($urandom);
				end
				for (int b = 0; b < MAX_BUTTONS; b++)
					if ($urandom_range(0, 11) == 0)
						held_now[b] = ~held_now[b];
				send_request(CMD_TICK, tick_now, held_now, MAX_BUTTONS'($urandom));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hold times still at their reset value; the deadline wraps past the top count.
		send_request(CMD_READ, 16'h0000, 4'b0000, 4'b0000);
		send_request(CMD_TICK, 16'hFFF0, 4'b1111, 4'b0000);
		send_request(CMD_TICK, 16'd83, 4'b1111, 4'b1111);
		send_request(CMD_TICK, 16'd84, 4'b1111, 4'b0000);
		send_request(CMD_READ, 16'hFFFF, 4'b0000, 4'b0000);
		send_request(CMD_READ, 16'h0000, 4'b1111, 4'b0001);
		send_request(CMD_READ, 16'h0000, 4'b0000, 4'b1111);
		send_request(CMD_READ, 16'h0000, 4'b0000, 4'b0000);
		send_request(CMD_TICK, 16'd85, 4'b0000, 4'b0000);
		wait_drained();

		// Zero hold time, minimum, maximum, and a deadline that the count skips over.
		load_hold_times(16'd0, 16'd1, 16'hFFFF, 16'd5);
		send_request(CMD_TICK, 16'h8000, 4'b1111, 4'b0000);
		send_request(CMD_TICK, 16'h8000, 4'b1111, 4'b0000);
		send_request(CMD_TICK, 16'h8001, 4'b1111, 4'b0000);
		send_request(CMD_TICK, 16'h8006, 4'b1111, 4'b0000);
		send_request(CMD_TICK, 16'h7FFF, 4'b1111, 4'b0000);
		send_request(CMD_TICK, 16'h8005, 4'b1011, 4'b0000);
		send_request(CMD_TICK, 16'h8006, 4'b0100, 4'b0000);
		send_request(CMD_TICK, 16'h8007, 4'b0000, 4'b0000);
		send_request(CMD_READ, 16'h0000, 4'b0000, 4'b1010);
		send_request(CMD_READ, 16'h0000, 4'b0000, 4'b0101);
		send_request(CMD_TICK, 16'hFFFF, 4'b1000, 4'b0000);
		send_request(CMD_TICK, 16'h0000, 4'b1000, 4'b1111);
		send_request(CMD_TICK, 16'h0004, 4'b1000, 4'b0000);
		send_request(CMD_READ, 16'h0000, 4'b1111, 4'b1111);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			case (p)
				0:       load_hold_times(16'd1, 16'd1, 16'd1, 16'd1);
				1:       load_hold_times(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				2:       load_hold_times(16'd0, 16'd1, 16'hFFFF, 16'd7);
				default: load_hold_times(pick_hold(), pick_hold(), pick_hold(), pick_hold());
			endcase
			if (p == HOLD_OFF_PHASE) begin
				// Keep offering requests back to back while the response side holds off.
				steady_sender = 1'b1;
				hold_off_asked <= hold_off_asked + 1;
			end
			run_phase(PHASE_REQUESTS);
			steady_sender = 1'b0;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
